[rtl/scl_pkg.sv]
// scl_pkg: types, codes and helper functions of the shell command lexer
// no dependencies; used by every module of the block

package scl_pkg;

    // input item and result item
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } t_in;

    typedef struct packed {
        logic [7:0] content_byte;
        logic       content_valid;
        logic       token_end;
        logic [1:0] quote_kind;
        logic [2:0] redir_kind;
        logic       pipe_flag;
        logic       space_after;
        logic       line_done;
    } t_out;

    localparam int unsigned MAX_RES = 3;

    // all results caused by one input item
    typedef struct packed {
        t_out [MAX_RES-1:0] res;
        logic [1:0]         cnt;
    } t_pkt;

    // lexer modes
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_WORD     = 3'd1;
    localparam logic [2:0] MODE_QUOTED   = 3'd2;
    localparam logic [2:0] MODE_ESCAPE   = 3'd3;
    localparam logic [2:0] MODE_OPERATOR = 3'd4;

    // pending operator codes (1..4 match redir_kind)
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_INPUT   = 3'd1;
    localparam logic [2:0] OP_OUTPUT  = 3'd2;
    localparam logic [2:0] OP_APPEND  = 3'd3;
    localparam logic [2:0] OP_HEREDOC = 3'd4;
    localparam logic [2:0] OP_PIPE    = 3'd5;

    // quote kinds
    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_SINGLE = 2'd1;
    localparam logic [1:0] Q_DOUBLE = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] held_byte;
        logic       held_valid;
        logic [1:0] open_quote;
        logic [2:0] pend_op;
        logic       close_pending;
    } t_lex;

    localparam t_lex LEX_CLEAR = '{
        mode: MODE_IDLE, held_byte: 8'h00, held_valid: 1'b0,
        open_quote: Q_NONE, pend_op: OP_NONE, close_pending: 1'b0
    };

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // build one result; kind fields only show on a token end
    function automatic t_out make_res(input logic [7:0] b, input logic v, input logic e,
                                      input logic [1:0] q, input logic [2:0] op,
                                      input logic sp);
        t_out r;
        r.content_byte  = b;
        r.content_valid = v;
        r.token_end     = e;
        r.quote_kind    = e ? q : Q_NONE;
        r.redir_kind    = (e && op >= OP_INPUT && op <= OP_HEREDOC) ? op : OP_NONE;
        r.pipe_flag     = e && (op == OP_PIPE);
        r.space_after   = e & sp;
        r.line_done     = 1'b0;
        return r;
    endfunction

    // state after the first byte of a new token
    function automatic t_lex begin_token(input logic [7:0] c);
        t_lex s;
        s = LEX_CLEAR;
        if (is_blank(c)) begin
            s = LEX_CLEAR;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            s.mode       = MODE_QUOTED;
            s.open_quote = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
        end else if (c == CH_PIPE) begin
            s.held_byte     = c;
            s.held_valid    = 1'b1;
            s.pend_op       = OP_PIPE;
            s.close_pending = 1'b1;
        end else if (c == CH_LT || c == CH_GT) begin
            s.mode       = MODE_OPERATOR;
            s.held_byte  = c;
            s.held_valid = 1'b1;
            s.pend_op    = (c == CH_LT) ? OP_INPUT : OP_OUTPUT;
        end else begin
            s.mode       = MODE_WORD;
            s.held_byte  = c;
            s.held_valid = 1'b1;
        end
        return s;
    endfunction

endpackage

[rtl/shell_command_lexer_top.sv]
// shell_command_lexer_top: streaming shell command-line tokenizer, top level
// depends on scl_pkg, scl_step and scl_serializer
//
// Takes one command-line byte per transfer and streams out shell tokens, one
// content byte per output transfer. Spaces and tabs split words; '|' is a
// one-byte pipe token; '<', '>', '<<', '>>' are redirections; quoted tokens
// come out without their quotes, and inside double quotes a backslash stays
// in the content and protects the next byte. One byte is held back so the
// last byte of each token carries its quote kind, redirection kind, pipe flag
// and whether whitespace follows. A byte may cause zero to two results
// (end of line flushes the open token and tags the last result line_done).
// Rate: one input byte per clock as long as each byte yields at most one
// result and the output is ready; the output port moves one result per
// clock while ready is high, so a byte that causes several results takes
// one output transfer per result. A byte passes through the input register,
// then the lexer step into the packet queue, whose head drives the output.

module shell_command_lexer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  scl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output scl_pkg::t_out o_out_data
);

    // input register
    logic          r_in_valid, n_in_valid;
    scl_pkg::t_in  r_in;

    // lexer state
    scl_pkg::t_lex r_lex;
    scl_pkg::t_lex w_lex_next;
    scl_pkg::t_pkt w_pkt;

    logic          w_room;
    logic          w_accept;
    logic          w_advance;

    // combinational lexer step on the registered byte
    scl_step u_step (
        .i_lex  (r_lex),
        .i_item (r_in),
        .o_lex  (w_lex_next),
        .o_pkt  (w_pkt)
    );

    always_comb begin
        // a byte with no results never needs queue room
        w_advance  = r_in_valid && (w_room || (w_pkt.cnt == 2'd0));
        o_in_ready = !r_in_valid || w_advance;
        w_accept   = i_in_valid && o_in_ready;
        n_in_valid = w_accept ? 1'b1 : (w_advance ? 1'b0 : r_in_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_lex      <= scl_pkg::LEX_CLEAR;
        end else begin
            r_in_valid <= n_in_valid;
            if (w_advance) begin
                r_lex <= w_lex_next;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    // result packets queued and sent out one transfer at a time
    scl_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_advance && (w_pkt.cnt != 2'd0)),
        .i_pkt   (w_pkt),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

[rtl/scl_step.sv]
// scl_step: next lexer state and result packet for one input byte
// depends on scl_pkg

module scl_step (
    input  scl_pkg::t_lex i_lex,
    input  scl_pkg::t_in  i_item,
    output scl_pkg::t_lex o_lex,
    output scl_pkg::t_pkt o_pkt
);

    logic [7:0]    c;
    logic          ws;
    logic [7:0]    qc;
    logic [1:0]    n;
    logic [1:0]    last;
    scl_pkg::t_lex s;
    scl_pkg::t_pkt p;

    always_comb begin
        c  = i_item.char_code;
        ws = scl_pkg::is_blank(c);
        qc = 8'h00;
        n  = 2'd0;
        p  = '0;
        s  = i_lex;

        // operator or quote closed on the previous byte
        if (s.close_pending) begin
            p.res[n] = scl_pkg::make_res(s.held_byte, s.held_valid, 1'b1,
                                         s.open_quote, s.pend_op, ws);
            n = n + 2'd1;
            s = scl_pkg::LEX_CLEAR;
        end

        case (s.mode)
            scl_pkg::MODE_WORD: begin
                if (c inside {scl_pkg::CH_SPACE, scl_pkg::CH_TAB, scl_pkg::CH_SQUOTE,
                              scl_pkg::CH_DQUOTE, scl_pkg::CH_PIPE, scl_pkg::CH_LT,
                              scl_pkg::CH_GT}) begin
                    p.res[n] = scl_pkg::make_res(s.held_byte, 1'b1, 1'b1,
                                                 scl_pkg::Q_NONE, scl_pkg::OP_NONE, ws);
                    n = n + 2'd1;
                    s = scl_pkg::begin_token(c);
                end else begin
                    p.res[n] = scl_pkg::make_res(s.held_byte, 1'b1, 1'b0,
                                                 scl_pkg::Q_NONE, scl_pkg::OP_NONE, 1'b0);
                    n = n + 2'd1;
                    s.held_byte = c;
                end
            end
            scl_pkg::MODE_OPERATOR: begin
                if ((c == scl_pkg::CH_LT && s.pend_op == scl_pkg::OP_INPUT) ||
                    (c == scl_pkg::CH_GT && s.pend_op == scl_pkg::OP_OUTPUT)) begin
                    p.res[n] = scl_pkg::make_res(s.held_byte, 1'b1, 1'b0,
                                                 scl_pkg::Q_NONE, scl_pkg::OP_NONE, 1'b0);
                    n = n + 2'd1;
                    s.held_byte     = c;
                    s.pend_op       = (c == scl_pkg::CH_LT) ? scl_pkg::OP_HEREDOC
                                                            : scl_pkg::OP_APPEND;
                    s.mode          = scl_pkg::MODE_IDLE;
                    s.close_pending = 1'b1;
                end else begin
                    p.res[n] = scl_pkg::make_res(s.held_byte, 1'b1, 1'b1,
                                                 scl_pkg::Q_NONE, s.pend_op, ws);
                    n = n + 2'd1;
                    s = scl_pkg::begin_token(c);
                end
            end
            scl_pkg::MODE_QUOTED: begin
                qc = (s.open_quote == scl_pkg::Q_SINGLE) ? scl_pkg::CH_SQUOTE
                                                         : scl_pkg::CH_DQUOTE;
                if (c == qc) begin
                    s.mode          = scl_pkg::MODE_IDLE;
                    s.close_pending = 1'b1;
                end else begin
                    if (s.held_valid) begin
                        p.res[n] = scl_pkg::make_res(s.held_byte, 1'b1, 1'b0,
                                                     scl_pkg::Q_NONE, scl_pkg::OP_NONE, 1'b0);
                        n = n + 2'd1;
                    end
                    s.held_byte  = c;
                    s.held_valid = 1'b1;
                    if (s.open_quote == scl_pkg::Q_DOUBLE && c == scl_pkg::CH_BSLASH) begin
                        s.mode = scl_pkg::MODE_ESCAPE;
                    end
                end
            end
            scl_pkg::MODE_ESCAPE: begin
                p.res[n] = scl_pkg::make_res(s.held_byte, s.held_valid, 1'b0,
                                             scl_pkg::Q_NONE, scl_pkg::OP_NONE, 1'b0);
                n = n + 2'd1;
                s.held_byte  = c;
                s.held_valid = 1'b1;
                s.mode       = scl_pkg::MODE_QUOTED;
            end
            default: begin
                s = scl_pkg::begin_token(c);
            end
        endcase

        // flush whatever is open at the end of the line
        if (i_item.end_of_line) begin
            if (s.close_pending) begin
                p.res[n] = scl_pkg::make_res(s.held_byte, s.held_valid, 1'b1,
                                             s.open_quote, s.pend_op, 1'b0);
                n = n + 2'd1;
            end else if (s.mode == scl_pkg::MODE_WORD) begin
                p.res[n] = scl_pkg::make_res(s.held_byte, 1'b1, 1'b1,
                                             scl_pkg::Q_NONE, scl_pkg::OP_NONE, 1'b0);
                n = n + 2'd1;
            end else if (s.mode == scl_pkg::MODE_OPERATOR) begin
                p.res[n] = scl_pkg::make_res(s.held_byte, 1'b1, 1'b1,
                                             scl_pkg::Q_NONE, s.pend_op, 1'b0);
                n = n + 2'd1;
            end else if (s.mode == scl_pkg::MODE_QUOTED || s.mode == scl_pkg::MODE_ESCAPE) begin
                // unterminated quote: held byte is dropped
                p.res[n] = scl_pkg::make_res(8'h00, 1'b0, 1'b1,
                                             s.open_quote, scl_pkg::OP_NONE, 1'b0);
                n = n + 2'd1;
            end
            if (n == 2'd0) begin
                p.res[n] = scl_pkg::make_res(8'h00, 1'b0, 1'b0,
                                             scl_pkg::Q_NONE, scl_pkg::OP_NONE, 1'b0);
                n = n + 2'd1;
            end
            last = n - 2'd1;
            p.res[last].line_done = 1'b1;
            s = scl_pkg::LEX_CLEAR;
        end else begin
            last = 2'd0;
        end

        p.cnt = n;
        o_lex = s;
        o_pkt = p;
    end

endmodule

[rtl/scl_serializer.sv]
// scl_serializer: two-deep queue of result packets, sent one result per transfer
// depends on scl_pkg

module scl_serializer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scl_pkg::t_pkt i_pkt,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output scl_pkg::t_out o_data
);

    scl_pkg::t_pkt r_pkt [2];
    logic          r_wp, n_wp;
    logic          r_rp, n_rp;
    logic [1:0]    r_cnt, n_cnt;
    logic [1:0]    r_idx, n_idx;

    scl_pkg::t_pkt head;
    logic          pop;
    logic          step;

    always_comb begin
        head    = r_pkt[r_rp];
        o_valid = (r_cnt != 2'd0);
        o_data  = head.res[r_idx];
        o_room  = (r_cnt != 2'd2);
        step    = o_valid && i_ready;
        pop     = step && (r_idx == head.cnt - 2'd1);

        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, pop};
        n_idx = pop ? 2'd0 : (step ? r_idx + 2'd1 : r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_pkt[r_wp] <= i_pkt;
        end
    end

endmodule

[sim/scl_token_checker.sv]
`timescale 1ns / 1ps
// scl_token_checker: predicts and checks the token stream of the shell command lexer
// depends on scl_pkg for the transfer types, codes and character constants

module scl_token_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  scl_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  scl_pkg::t_out i_out_data,
    output int            o_mismatches,
    output int            o_outstanding,
    output int            o_checked,
    output int            o_tokens
);
    import scl_pkg::*;

    // predicted lexer state
    logic [2:0] tok_mode   = MODE_IDLE;
    logic [7:0] hold_byte  = 8'h00;
    logic       hold_vld   = 1'b0;
    logic [1:0] quote_open = Q_NONE;
    logic [2:0] op_pending = OP_NONE;
    logic       close_due  = 1'b0;

    t_out token_stream_q[$];
    t_out step_res[MAX_RES];
    int   step_n;

    int mismatch_cnt    = 0;
    int outstanding_cnt = 0;
    int checked_cnt     = 0;
    int token_cnt       = 0;

    assign o_mismatches  = mismatch_cnt;
    assign o_outstanding = outstanding_cnt;
    assign o_checked     = checked_cnt;
    assign o_tokens      = token_cnt;

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic string fmt_res(input t_out r);
        return $sformatf("byte=%02h vld=%0d end=%0d quote=%0d redir=%0d pipe=%0d space=%0d done=%0d",
                         r.content_byte, r.content_valid, r.token_end, r.quote_kind,
                         r.redir_kind, r.pipe_flag, r.space_after, r.line_done);
    endfunction

    task clear_lexer();
        tok_mode   = MODE_IDLE;
        hold_byte  = 8'h00;
        hold_vld   = 1'b0;
        quote_open = Q_NONE;
        op_pending = OP_NONE;
        close_due  = 1'b0;
    endtask

    task add_res(input logic [7:0] b, input logic v, input logic e, input logic [1:0] q,
                 input logic [2:0] op, input logic sp);
        t_out r;
        if (step_n < MAX_RES) begin
            r.content_byte  = b;
            r.content_valid = v;
            r.token_end     = e;
            r.quote_kind    = e ? q : Q_NONE;
            r.redir_kind    = (e && op >= OP_INPUT && op <= OP_HEREDOC) ? op : OP_NONE;
            r.pipe_flag     = e && (op == OP_PIPE);
            r.space_after   = e && sp;
            r.line_done     = 1'b0;
            step_res[step_n] = r;
            step_n++;
        end
    endtask

    // first byte of a token decides what kind it is
    task start_token(input logic [7:0] c);
        clear_lexer();
        if (blank_char(c)) begin
            return;
        end
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            tok_mode   = MODE_QUOTED;
            quote_open = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
        end else if (c == CH_PIPE) begin
            hold_byte  = c;
            hold_vld   = 1'b1;
            op_pending = OP_PIPE;
            close_due  = 1'b1;
        end else if (c == CH_LT || c == CH_GT) begin
            tok_mode   = MODE_OPERATOR;
            hold_byte  = c;
            hold_vld   = 1'b1;
            op_pending = (c == CH_LT) ? OP_INPUT : OP_OUTPUT;
        end else begin
            tok_mode  = MODE_WORD;
            hold_byte = c;
            hold_vld  = 1'b1;
        end
    endtask

    // one accepted byte in, zero to two predicted results out
    task lex_byte(input t_in item);
        logic [7:0] c;
        logic       ws;
        logic [7:0] qc;
        c      = item.char_code;
        ws     = blank_char(c);
        step_n = 0;

        if (close_due) begin
            add_res(hold_byte, hold_vld, 1'b1, quote_open, op_pending, ws);
            clear_lexer();
        end

        case (tok_mode)
            MODE_WORD: begin
                if (ws || c == CH_SQUOTE || c == CH_DQUOTE || c == CH_PIPE ||
                    c == CH_LT || c == CH_GT) begin
                    add_res(hold_byte, 1'b1, 1'b1, Q_NONE, OP_NONE, ws);
                    start_token(c);
                end else begin
                    add_res(hold_byte, 1'b1, 1'b0, Q_NONE, OP_NONE, 1'b0);
                    hold_byte = c;
                end
            end
            MODE_OPERATOR: begin
                if ((c == CH_LT && op_pending == OP_INPUT) ||
                    (c == CH_GT && op_pending == OP_OUTPUT)) begin
                    add_res(hold_byte, 1'b1, 1'b0, Q_NONE, OP_NONE, 1'b0);
                    hold_byte  = c;
                    op_pending = (c == CH_LT) ? OP_HEREDOC : OP_APPEND;
                    tok_mode   = MODE_IDLE;
                    close_due  = 1'b1;
                end else begin
                    add_res(hold_byte, 1'b1, 1'b1, Q_NONE, op_pending, ws);
                    start_token(c);
                end
            end
            MODE_QUOTED: begin
                qc = (quote_open == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
                if (c == qc) begin
                    tok_mode  = MODE_IDLE;
                    close_due = 1'b1;
                end else begin
                    if (hold_vld) begin
                        add_res(hold_byte, 1'b1, 1'b0, Q_NONE, OP_NONE, 1'b0);
                    end
                    hold_byte = c;
                    hold_vld  = 1'b1;
                    if (quote_open == Q_DOUBLE && c == CH_BSLASH) begin
                        tok_mode = MODE_ESCAPE;
                    end
                end
            end
            MODE_ESCAPE: begin
                add_res(hold_byte, hold_vld, 1'b0, Q_NONE, OP_NONE, 1'b0);
                hold_byte = c;
                hold_vld  = 1'b1;
                tok_mode  = MODE_QUOTED;
            end
            default: begin
                start_token(c);
            end
        endcase

        if (item.end_of_line) begin
            if (close_due) begin
                add_res(hold_byte, hold_vld, 1'b1, quote_open, op_pending, 1'b0);
            end else if (tok_mode == MODE_WORD) begin
                add_res(hold_byte, 1'b1, 1'b1, Q_NONE, OP_NONE, 1'b0);
            end else if (tok_mode == MODE_OPERATOR) begin
                add_res(hold_byte, 1'b1, 1'b1, Q_NONE, op_pending, 1'b0);
            end else if (tok_mode == MODE_QUOTED || tok_mode == MODE_ESCAPE) begin
                // unterminated quote: held byte is dropped, marker closes it
                add_res(8'h00, 1'b0, 1'b1, quote_open, OP_NONE, 1'b0);
            end
            if (step_n == 0) begin
                add_res(8'h00, 1'b0, 1'b0, Q_NONE, OP_NONE, 1'b0);
            end
            step_res[step_n-1].line_done = 1'b1;
            clear_lexer();
        end

        for (int i = 0; i < step_n; i++) begin
            token_stream_q.push_back(step_res[i]);
        end
    endtask

    task check_result(input t_out got);
        t_out want;
        if (token_stream_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("%0t: unexpected result: %s", $realtime, fmt_res(got));
            end
        end else begin
            want = token_stream_q.pop_front();
            checked_cnt++;
            if (got.token_end) begin
                token_cnt++;
            end
            if (got !== want) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("    expected: %s", fmt_res(want));
                    $display("    actual:   %s", fmt_res(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lexer();
            token_stream_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                lex_byte(i_in_data);
            end
        end
        outstanding_cnt = token_stream_q.size();
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: drives command lines into shell_command_lexer_top and gives the verdict
// depends on scl_pkg, the lexer rtl and scl_token_checker

module testbench;
    import scl_pkg::*;

    // watchdog: cycles in a row with no transfer on either channel
    localparam int STALL_LIMIT = 3000;
    // length of the forced output hold-off, in cycles
    localparam int LONG_HOLD   = 300;
    // random bytes per idling phase
    localparam int PHASE_BYTES = 40;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    t_in   in_data   = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_out  out_data;

    int mismatches;
    int outstanding;
    int checked;
    int tokens;

    // sender idling is used by the stimulus process only, receiver idling by its own process
    int tx_idle_pct = 9;
    int rx_idle_pct = 66;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int stall_seq   = 0;

    int bytes_sent  = 0;
    int lines_sent  = 0;
    int quiet_cycles = 0;

    logic [7:0] line_buf[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    shell_command_lexer_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    scl_token_checker token_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_tokens      (tokens)
    );

    // watchdog: ends the run if neither channel moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results still due",
                     STALL_LIMIT, outstanding);
            $display("shell_command_lexer_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq  = 0;
        forever begin
            @(posedge clk);
            if (stall_seq != seen_seq) begin
                seen_seq  = stall_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // bytes that end a word when unquoted
    function automatic logic special_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_SQUOTE || c == CH_DQUOTE ||
               c == CH_PIPE || c == CH_LT || c == CH_GT;
    endfunction

    // ordinary word byte: half lower-case letters, half any non-special byte
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 1) begin
            c = 8'h61 + 8'($urandom_range(0, 25));
        end else begin
            do c = 8'($urandom_range(0, 255)); while (special_char(c));
        end
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(0, 1) == 1) ? CH_SPACE : CH_TAB;
    endfunction

    // one input transfer; called at a rising edge, returns at the edge that took it
    task send_byte(input logic [7:0] c, input logic eol);
        t_in item;
        bit  taken;
        item.char_code   = c;
        item.end_of_line = eol;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        taken = 1'b0;
        // ready is settled by the falling edge, inputs only move at rising edges
        while (!taken) begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // send line_buf with the end-of-line flag on its last byte
    task send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_byte(line_buf[i], i == line_buf.size() - 1);
        end
        lines_sent++;
        line_buf.delete();
    endtask

    task push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endtask

    // sender pauses until every predicted result has been taken
    task wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    // one random token; an unterminated quote has to be the last thing on the line
    task add_token(output bit line_over);
        int         k;
        int         n;
        logic [7:0] c;
        line_over = 1'b0;
        k = $urandom_range(0, 99);
        if (k < 30) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) line_buf.push_back(plain_char());
        end else if (k < 42) begin
            line_buf.push_back(CH_PIPE);
        end else if (k < 50) begin
            line_buf.push_back(CH_LT);
        end else if (k < 58) begin
            line_buf.push_back(CH_GT);
        end else if (k < 64) begin
            line_buf.push_back(CH_LT);
            line_buf.push_back(CH_LT);
        end else if (k < 70) begin
            line_buf.push_back(CH_GT);
            line_buf.push_back(CH_GT);
        end else if (k < 82) begin
            // single quoted, anything but the closing quote inside
            line_buf.push_back(CH_SQUOTE);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_SQUOTE);
                line_buf.push_back(c);
            end
            line_buf.push_back(CH_SQUOTE);
        end else if (k < 96) begin
            // double quoted, with the odd backslash escape
            line_buf.push_back(CH_DQUOTE);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(8'($urandom_range(0, 255)));
                end else begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_DQUOTE || c == CH_BSLASH);
                    line_buf.push_back(c);
                end
            end
            line_buf.push_back(CH_DQUOTE);
        end else begin
            // broken: quote never closed
            line_buf.push_back(($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_DQUOTE);
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++) line_buf.push_back(plain_char());
            line_over = 1'b1;
        end
    endtask

    // mostly well-formed command lines, some raw noise and blank-only lines
    task build_line();
        int kind;
        int n;
        bit over;
        kind = $urandom_range(0, 99);
        over = 1'b0;
        if (kind < 15) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 20) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) line_buf.push_back(blank_byte());
        end else begin
            if ($urandom_range(0, 3) == 0) line_buf.push_back(blank_byte());
            n = $urandom_range(1, 4);
            for (int i = 0; i < n && !over; i++) begin
                add_token(over);
                // adjacent tokens without a blank are kept on purpose
                if (!over && $urandom_range(0, 2) != 0) begin
                    line_buf.push_back(blank_byte());
                    if ($urandom_range(0, 3) == 0) line_buf.push_back(blank_byte());
                end
            end
        end
    endtask

    initial begin : stimulus
        int phase_start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed lines: word and pipe, heredoc and append, input and output
        // split by a tab, empty quotes, escaped quote left open, lone quote,
        // blank-only line, zero and all-ones bytes as a word, open single quote
        push_text("a|b");
        send_line();
        push_text("<<x>>");
        send_line();
        push_text("<\t>");
        send_line();
        push_text("''");
        send_line();
        push_text("\"\\\"");
        send_line();
        push_text("\"");
        send_line();
        push_text(" ");
        send_line();
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        send_line();
        push_text("'q");
        send_line();
        wait_drained();

        // random lines: sender sparse / receiver slow, the reverse, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 9;
                    rx_idle_pct <= 66;
                end
                1: begin
                    tx_idle_pct = 66;
                    rx_idle_pct <= 9;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    // receiver holds off while the sender keeps offering bytes
                    stall_seq <= stall_seq + 1;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_line();
                send_line();
            end
            wait_drained();
        end

        // keep the clock running so a stray late result would still be seen
        repeat (8) @(posedge clk);

        $display("sent %0d bytes in %0d command lines: directed cases, then random lines",
                 bytes_sent, lines_sent);
        $display("under both idling mixes, full rate and a long output hold-off;");
        $display("%0d results, %0d tokens checked", checked, tokens);
        if (mismatches == 0 && outstanding == 0) begin
            $display("shell_command_lexer_top regression: pass");
        end else begin
            $display("shell_command_lexer_top regression: fail");
        end
        $finish;
    end

endmodule
